>>> sv/scd_pkg.sv
// scd_pkg: widths, codes, the queue item type and the ratio helpers
// shared by the smoothed cosine similarity core. No dependencies.
`default_nettype none
package scd_pkg;
   localparam int COUNT_BITS = 20;
   localparam int FRAC_BITS  = 24;
   localparam int ALPHA_FRAC = 16;
   localparam int CNT_W      = COUNT_BITS + 1;
   localparam int ALPHA_W    = 32;
   localparam int ND_W       = COUNT_BITS + ALPHA_FRAC + 1;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int PROD_W     = 2 * Q_W;
   localparam int SUM_W      = 64;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int STEP_W     = $clog2(FRAC_BITS);
   localparam int ROOT_STEP_W = $clog2(ROOT_W);
   localparam int CSR_IDX_W  = 1;

   localparam logic [Q_W-1:0] QMAX = '1;
   localparam logic [Q_W-1:0] LIMIT_101 = Q_W'((64'd101 << FRAC_BITS) / 64'd100);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 32'd6554;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_SECOND = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NEG   = 2'd1;
   localparam logic [1:0] STATUS_ZERO  = 2'd2;
   localparam logic [1:0] STATUS_ABOVE = 2'd3;

   typedef struct packed {
      logic [ND_W-1:0] num_a;
      logic [ND_W-1:0] den_a;
      logic [ND_W-1:0] num_b;
      logic [ND_W-1:0] den_b;
      logic            neg_a;
      logic            last;
   } scd_item_type;

   // count + alpha in Q.16, clamped at zero for a negative count
   function automatic logic [ND_W-1:0] smooth_num(input logic [CNT_W-1:0] cnt,
                                                  input logic [ALPHA_W-1:0] alpha);
      logic            neg;
      logic [CNT_W-1:0] mag;
      logic [ND_W-1:0] cm;
      logic [ND_W-1:0] al;
      neg = cnt[CNT_W-1];
      mag = neg ? (~cnt + CNT_W'(1)) : cnt;
      cm  = ND_W'(mag) << ALPHA_FRAC;
      al  = ND_W'(alpha);
      if (neg) begin
         smooth_num = (cm > al) ? '0 : (al - cm);
      end else begin
         smooth_num = cm + al;
      end
   endfunction

   function automatic logic [ND_W-1:0] smooth_den(input logic [COUNT_BITS-1:0] total,
                                                  input logic [ALPHA_W-1:0] alpha);
      smooth_den = (ND_W'(total) << ALPHA_FRAC) + ND_W'(alpha);
   endfunction
endpackage
`default_nettype wire

>>> sv/scd_if.sv
// scd_if: valid/ready channel interfaces for requests, responses and
// register writes. Depends on scd_pkg.
`default_nettype none
interface scd_req_if import scd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CNT_W-1:0] count_first;
   logic signed [CNT_W-1:0] count_second;
   logic [COUNT_BITS-1:0]   doc_total;
   logic                    last_doc;
   modport source (output valid, count_first, count_second, doc_total, last_doc,
                   input ready);
   modport sink   (input valid, count_first, count_second, doc_total, last_doc,
                   output ready);
endinterface

interface scd_rsp_if import scd_pkg::*; ();
   logic           valid;
   logic           ready;
   logic [Q_W-1:0] similarity;
   logic [1:0]     status;
   modport source (output valid, similarity, status, input ready);
   modport sink   (input valid, similarity, status, output ready);
endinterface

interface scd_csr_if import scd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ALPHA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/scd_front.sv
// scd_front: accepts requests, forms the smoothed numerators and
// denominators and holds them in a two-entry queue. Depends on scd_pkg, scd_if.
`default_nettype none
module scd_front import scd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   scd_req_if.sink                 req_ch,
   input  wire logic [ALPHA_W-1:0] alpha_first,
   input  wire logic [ALPHA_W-1:0] alpha_second,
   input  wire logic               pop,
   output logic                    q_valid,
   output scd_item_type            q_head
);
   scd_item_type entry_ff [2];
   scd_item_type item;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push    = req_ch.valid && req_ch.ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      item.num_a = smooth_num(req_ch.count_first, alpha_first);
      item.den_a = smooth_den(req_ch.doc_total, alpha_first);
      item.num_b = smooth_num(req_ch.count_second, alpha_second);
      item.den_b = smooth_den(req_ch.doc_total, alpha_second);
      item.neg_a = req_ch.count_first[CNT_W-1];
      item.last  = req_ch.last_doc;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end
endmodule
`default_nettype wire

>>> sv/scd_div.sv
// scd_div: restoring divider giving a saturated Q1.24 quotient, one
// fraction bit per cycle, fixed latency. Depends on scd_pkg.
`default_nettype none
module scd_div import scd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] num,
   input  wire logic [SUM_W-1:0] den,
   output logic                  done,
   output logic [Q_W-1:0]        quot
);
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              fixed_ff, fixed_in;
   logic              done_ff, done_in;
   logic [SUM_W:0]    shifted;
   logic              ge;
   logic              int_one;

   assign done = done_ff;
   assign quot = q_ff;

   always_comb begin
      shifted  = {rem_ff, 1'b0};
      ge       = shifted >= {1'b0, den_ff};
      int_one  = num >= den;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      fixed_in = fixed_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         den_in   = den;
         fixed_in = 1'b1;
         rem_in   = '0;
         if (den == '0) begin
            q_in = (num != '0) ? QMAX : '0;
         end else if ({1'b0, num} >= {den, 1'b0}) begin
            q_in = QMAX;
         end else begin
            fixed_in = 1'b0;
            q_in     = Q_W'(int_one);
            rem_in   = int_one ? (num - den) : num;
         end
      end else if (busy_ff) begin
         if (!fixed_ff) begin
            rem_in = ge ? SUM_W'(shifted - {1'b0, den_ff}) : shifted[SUM_W-1:0];
            q_in   = {q_ff[Q_W-2:0], ge};
         end
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      fixed_ff <= fixed_in;
   end
endmodule
`default_nettype wire

>>> sv/scd_sqrt.sv
// scd_sqrt: bit-pair integer square root of a 64-bit sum, one result bit
// per cycle for a 32-bit root. Depends on scd_pkg.
`default_nettype none
module scd_sqrt import scd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] value,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);
   logic [SUM_W-1:0]       x_ff, x_in;
   logic [SUM_W-1:0]       r_ff, r_in;
   logic [ROOT_STEP_W-1:0] cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [SUM_W-1:0]       bitv;
   logic [SUM_W-1:0]       trial;

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

   always_comb begin
      bitv    = SUM_W'(1) << {cnt_ff, 1'b0};
      trial   = r_ff + bitv;
      x_in    = x_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = value;
         r_in    = '0;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bitv;
         end else begin
            r_in = r_ff >> 1;
         end
         cnt_in = cnt_ff - ROOT_STEP_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

>>> sv/scd_back.sv
// scd_back: sequencer that divides, accumulates and, on the last document,
// takes the roots, divides again and drives the response register.
// Depends on scd_pkg, scd_if, scd_div, scd_sqrt.
`default_nettype none
module scd_back import scd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire scd_item_type q_head,
   output logic              pop,
   scd_rsp_if.source         rsp_ch
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIV     = 4'd1;
   localparam logic [3:0] S_MUL     = 4'd2;
   localparam logic [3:0] S_ACC     = 4'd3;
   localparam logic [3:0] S_SQRT_GO = 4'd4;
   localparam logic [3:0] S_SQRT    = 4'd5;
   localparam logic [3:0] S_PROD    = 4'd6;
   localparam logic [3:0] S_FIN     = 4'd7;
   localparam logic [3:0] S_FDIV    = 4'd8;
   localparam logic [3:0] S_OUT     = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic              neg_ff, neg_in;
   logic              last_ff, last_in;
   logic              negseen_ff, negseen_in;
   logic [Q_W-1:0]    da_ff, da_in, db_ff, db_in;
   logic [PROD_W-1:0] pab_ff, pab_in, paa_ff, paa_in, pbb_ff, pbb_in;
   logic [SUM_W-1:0]  dot_ff, dot_in, na_ff, na_in, nb_ff, nb_in;
   logic [ROOT_W-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [Q_W-1:0]    res_sim_ff, res_sim_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic              out_valid_ff, out_valid_in;
   logic [Q_W-1:0]    out_sim_ff, out_sim_in;
   logic [1:0]        out_st_ff, out_st_in;

   logic              div_a_start, div_b_start, div_a_done, div_b_done;
   logic [SUM_W-1:0]  div_a_num, div_a_den;
   logic [Q_W-1:0]    qa, qb;
   logic              sqrt_start, sqrt_a_done, sqrt_b_done;
   logic [ROOT_W-1:0] root_a, root_b;
   logic [SUM_W:0]    sum_dot, sum_na, sum_nb;

   scd_div u_div_a (.clock, .reset, .start(div_a_start), .num(div_a_num),
                    .den(div_a_den), .done(div_a_done), .quot(qa));
   scd_div u_div_b (.clock, .reset, .start(div_b_start), .num(SUM_W'(q_head.num_b)),
                    .den(SUM_W'(q_head.den_b)), .done(div_b_done), .quot(qb));
   scd_sqrt u_sqrt_a (.clock, .reset, .start(sqrt_start), .value(na_ff),
                      .done(sqrt_a_done), .root(root_a));
   scd_sqrt u_sqrt_b (.clock, .reset, .start(sqrt_start), .value(nb_ff),
                      .done(sqrt_b_done), .root(root_b));

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.similarity = out_sim_ff;
   assign rsp_ch.status     = out_st_ff;

   always_comb begin
      sum_dot = {1'b0, dot_ff} + (SUM_W+1)'(pab_ff);
      sum_na  = {1'b0, na_ff} + (SUM_W+1)'(paa_ff);
      sum_nb  = {1'b0, nb_ff} + (SUM_W+1)'(pbb_ff);
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      negseen_in   = negseen_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      pab_in       = pab_ff;
      paa_in       = paa_ff;
      pbb_in       = pbb_ff;
      dot_in       = dot_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      den_in       = den_ff;
      res_sim_in   = res_sim_ff;
      res_st_in    = res_st_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_sim_in   = out_sim_ff;
      out_st_in    = out_st_ff;
      pop          = 1'b0;
      div_a_start  = 1'b0;
      div_b_start  = 1'b0;
      div_a_num    = SUM_W'(q_head.num_a);
      div_a_den    = SUM_W'(q_head.den_a);
      sqrt_start   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop         = 1'b1;
               div_a_start = 1'b1;
               div_b_start = 1'b1;
               neg_in      = q_head.neg_a;
               last_in     = q_head.last;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            if (div_a_done && div_b_done) begin
               da_in    = qa;
               db_in    = qb;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            pab_in   = da_ff * db_ff;
            paa_in   = da_ff * da_ff;
            pbb_in   = db_ff * db_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            // accumulators saturate rather than wrap
            dot_in     = sum_dot[SUM_W] ? '1 : sum_dot[SUM_W-1:0];
            na_in      = sum_na[SUM_W] ? '1 : sum_na[SUM_W-1:0];
            nb_in      = sum_nb[SUM_W] ? '1 : sum_nb[SUM_W-1:0];
            negseen_in = negseen_ff || neg_ff;
            state_in   = last_ff ? S_SQRT_GO : S_IDLE;
         end
         S_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = S_SQRT;
         end
         S_SQRT: begin
            if (sqrt_a_done && sqrt_b_done) begin
               sa_in    = root_a;
               sb_in    = root_b;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            den_in   = sa_ff * sb_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            priority if (negseen_ff) begin
               res_sim_in = '0;
               res_st_in  = STATUS_NEG;
               state_in   = S_OUT;
            end else if (den_ff == '0) begin
               res_sim_in = '0;
               res_st_in  = STATUS_ZERO;
               state_in   = S_OUT;
            end else begin
               div_a_start = 1'b1;
               div_a_num   = dot_ff;
               div_a_den   = den_ff;
               state_in    = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_a_done) begin
               res_sim_in = qa;
               res_st_in  = (qa > LIMIT_101) ? STATUS_ABOVE : STATUS_OK;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_sim_in   = res_sim_ff;
               out_st_in    = res_st_ff;
               dot_in       = '0;
               na_in        = '0;
               nb_in        = '0;
               negseen_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         negseen_ff   <= 1'b0;
         dot_ff       <= '0;
         na_ff        <= '0;
         nb_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         negseen_ff   <= negseen_in;
         dot_ff       <= dot_in;
         na_ff        <= na_in;
         nb_ff        <= nb_in;
         out_valid_ff <= out_valid_in;
      end
      neg_ff     <= neg_in;
      last_ff    <= last_in;
      da_ff      <= da_in;
      db_ff      <= db_in;
      pab_ff     <= pab_in;
      paa_ff     <= paa_in;
      pbb_ff     <= pbb_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      den_ff     <= den_in;
      res_sim_ff <= res_sim_in;
      res_st_ff  <= res_st_in;
      out_sim_ff <= out_sim_in;
      out_st_ff  <= out_st_in;
   end
endmodule
`default_nettype wire

>>> sv/smoothed_cosine_similarity_core.sv
// smoothed_cosine_similarity_core: streams one document per request and
// returns the smoothed cosine similarity of two topic columns.
// Channels: req_ch (two signed counts, document total, last_doc flag),
// rsp_ch (Q1.24 similarity and 2-bit status), csr_ch (alpha_first at
// index 0, alpha_second at index 1, Q16.16; always ready).
// A request is taken into a two-entry queue; the back end works on one
// document at a time, with two parallel ratio dividers that produce
// one quotient bit per cycle over 24 fraction bits.
// The request carrying last_doc adds the two square roots and their
// product, the final division (skipped on an error status) and the
// load of the response register.
// Only last_doc requests give a response; the sums clear afterwards.
// Reset (synchronous) empties the queue, clears the sums and drops
// rsp_ch.valid; alphas return to 6554.
// A stalled response is held in the output register; the queue keeps
// taking requests until it is full, then req_ch.ready falls.
// Depends on scd_pkg, scd_if, scd_front, scd_back.
`default_nettype none
module smoothed_cosine_similarity_core import scd_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   scd_req_if.sink   req_ch,
   scd_rsp_if.source rsp_ch,
   scd_csr_if.sink   csr_ch
);
   logic [ALPHA_W-1:0] alpha_first_ff, alpha_first_in;
   logic [ALPHA_W-1:0] alpha_second_ff, alpha_second_in;
   logic               q_valid;
   logic               pop;
   scd_item_type       q_head;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      alpha_first_in  = alpha_first_ff;
      alpha_second_in = alpha_second_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_ALPHA_FIRST:  alpha_first_in  = csr_ch.data;
            REG_ALPHA_SECOND: alpha_second_in = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_first_ff  <= ALPHA_RESET;
         alpha_second_ff <= ALPHA_RESET;
      end else begin
         alpha_first_ff  <= alpha_first_in;
         alpha_second_ff <= alpha_second_in;
      end
   end

   scd_front u_front (
      .clock,
      .reset,
      .req_ch,
      .alpha_first(alpha_first_ff),
      .alpha_second(alpha_second_ff),
      .pop,
      .q_valid,
      .q_head
   );

   scd_back u_back (
      .clock,
      .reset,
      .q_valid,
      .q_head,
      .pop,
      .rsp_ch
   );

   // error responses carry a zero similarity
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == STATUS_NEG || rsp_ch.status == STATUS_ZERO)
      |-> rsp_ch.similarity == '0)
      else $error("error response with nonzero similarity");

   a_ok_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == STATUS_OK |-> rsp_ch.similarity <= LIMIT_101)
      else $error("ok status above limit");

   a_above_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == STATUS_ABOVE |-> rsp_ch.similarity > LIMIT_101)
      else $error("above status within limit");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");
endmodule
`default_nettype wire

>>> sim/smoothed_cosine_similarity_checker.sv
`timescale 1ns / 1ps
// smoothed_cosine_similarity_checker: watches request, response and register
// channels, predicts each response from its own model and compares.
// Depends on scd_pkg, scd_if.
module smoothed_cosine_similarity_checker import scd_pkg::*; (
   input  logic clock,
   input  logic reset,
   scd_req_if   req,
   scd_rsp_if   rsp,
   scd_csr_if   csr,
   output int   errors,
   output int   pending
);
   typedef struct packed {
      logic [Q_W-1:0] similarity;
      logic [1:0]     status;
   } cosine_result_t;

   cosine_result_t expected_cosines[$];
   logic [ALPHA_W-1:0] alpha_a, alpha_b;
   logic [63:0] dot_acc, norm_a_acc, norm_b_acc;
   logic        neg_flag;

   // truncated num/den in Q1.24, saturating at 2.0 and on n/0 with n nonzero
   function automatic logic [Q_W-1:0] frac_divide(input logic [63:0] num,
                                                  input logic [63:0] den);
      logic [64:0]    rem;
      logic [63:0]    whole;
      logic [Q_W-1:0] q;
      if (den == 0) return (num != 0) ? QMAX : '0;
      whole = num / den;
      if (whole > 1) return QMAX;
      q   = Q_W'(whole);
      rem = 65'(num - whole * den);
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= {1'b0, den}) begin
            rem   = rem - {1'b0, den};
            q[0]  = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [Q_W-1:0] smoothed_ratio(input logic [CNT_W-1:0] cnt,
                                                     input logic [COUNT_BITS-1:0] total,
                                                     input logic [ALPHA_W-1:0] alpha);
      logic [63:0] mag, scaled, num, den;
      mag    = cnt[CNT_W-1] ? (64'(1) << CNT_W) - 64'(cnt) : 64'(cnt);
      scaled = mag << ALPHA_FRAC;
      if (cnt[CNT_W-1]) num = (scaled > 64'(alpha)) ? 64'd0 : 64'(alpha) - scaled;
      else num = scaled + 64'(alpha);
      den = (64'(total) << ALPHA_FRAC) + 64'(alpha);
      return frac_divide(num, den);
   endfunction

   function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      logic [Q_W-1:0] ra, rb;
      logic [63:0]    den;
      cosine_result_t res, got;
      if (reset) begin
         alpha_a = ALPHA_RESET;
         alpha_b = ALPHA_RESET;
         dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0; neg_flag = 0;
         expected_cosines.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == REG_ALPHA_FIRST) alpha_a = csr.data;
            else if (csr.index == REG_ALPHA_SECOND) alpha_b = csr.data;
         end
         if (req.valid && req.ready) begin
            ra = smoothed_ratio(req.count_first, req.doc_total, alpha_a);
            rb = smoothed_ratio(req.count_second, req.doc_total, alpha_b);
            if (req.count_first[CNT_W-1]) neg_flag = 1;
            dot_acc    = sum_sat(dot_acc, 64'(ra) * 64'(rb));
            norm_a_acc = sum_sat(norm_a_acc, 64'(ra) * 64'(ra));
            norm_b_acc = sum_sat(norm_b_acc, 64'(rb) * 64'(rb));
            if (req.last_doc) begin
               den = floor_sqrt(norm_a_acc) * floor_sqrt(norm_b_acc);
               res.similarity = '0;
               if (neg_flag) res.status = STATUS_NEG;
               else if (den == 0) res.status = STATUS_ZERO;
               else begin
                  res.similarity = frac_divide(dot_acc, den);
                  res.status = (res.similarity > LIMIT_101) ? STATUS_ABOVE : STATUS_OK;
               end
               expected_cosines.insert(expected_cosines.size(), res);
               dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0; neg_flag = 0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            got.similarity = rsp.similarity;
            got.status     = rsp.status;
            if (expected_cosines.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response sim=%h status=%0d",
                                          got.similarity, got.status);
            end else begin
               res = expected_cosines.pop_front();
               if (got !== res) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected sim=%h status=%0d, got sim=%h status=%0d",
                              res.similarity, res.status, got.similarity, got.status);
               end
            end
         end
      end
      pending = expected_cosines.size();
   end

   initial begin
      errors  = 0;
      pending = 0;
   end
endmodule

>>> sim/smoothed_cosine_similarity_core_tb.sv
`timescale 1ns / 1ps
// smoothed_cosine_similarity_core_tb: drives requests and alpha writes into the core
// and gives the verdict. Depends on scd_pkg, scd_if, the core and the checker.
module smoothed_cosine_similarity_core_tb;
   import scd_pkg::*;

   logic clock = 0;
   logic reset = 1;
   int   errors, pending;
   int   docs_sent = 0;
   bit   quiet = 0;
   bit   hold_req = 0;

   scd_req_if req_ch ();
   scd_rsp_if rsp_ch ();
   scd_csr_if csr_ch ();

   smoothed_cosine_similarity_core u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   smoothed_cosine_similarity_checker u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .errors(errors), .pending(pending)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_doc(input logic [CNT_W-1:0] cf, input logic [CNT_W-1:0] cs,
                           input logic [COUNT_BITS-1:0] tot, input logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.count_first  <= cf;
      req_ch.count_second <= cs;
      req_ch.doc_total    <= tot;
      req_ch.last_doc     <= last;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      docs_sent++;
   endtask

   // only while idle: every expected response has come and the back end has drained
   task automatic write_alpha(input logic [CSR_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] val);
      req_ch.valid <= 1'b0;
      // let the checker count the last accepted request first
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(negedge clock); while (!csr_ch.ready);
      @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_docs(input int n);
      int len, pick, total;
      logic [CNT_W-1:0] cf, cs;
      logic [COUNT_BITS-1:0] tot;
      int sent;
      sent = 0;
      while (sent < n) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            pick  = $urandom_range(0, 99);
            total = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575)
                                               : $urandom_range(0, 1000);
            tot = COUNT_BITS'(total);
            cf  = CNT_W'($urandom_range(0, total));
            cs  = CNT_W'($urandom_range(0, total));
            if (pick >= 97) begin
               cf  = CNT_W'($urandom);
               cs  = CNT_W'($urandom);
               tot = COUNT_BITS'($urandom);
            end else if (pick >= 94) cf = -CNT_W'($urandom_range(1, 1048576));
            else if (pick >= 86) cs = -CNT_W'($urandom_range(1, 1048576));
            if (docs_sent > 650) quiet = 1;
            if (sent == 60) hold_req = 1;
            send_doc(cf, cs, tot, k == len - 1);
            sent++;
         end
      end
   endtask

   // response side: random stall bursts, one long hold-off to fill the queue
   initial begin
      bit held;
      held = 0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req && !held) begin
            rsp_ch.ready <= 1'b0;
            repeat (600) @(posedge clock);
            held = 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.count_first  <= '0;
      req_ch.count_second <= '0;
      req_ch.doc_total    <= '0;
      req_ch.last_doc     <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= REG_ALPHA_FIRST;
      csr_ch.data         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset alphas
      send_doc(21'sd1048575, 21'sd1048575, 20'hFFFFF, 1'b1);
      send_doc(-21'sd1048576, 21'sd3, 20'd10, 1'b1);     // negative first count
      send_doc(21'sd2, -21'sd1048576, 20'd10, 1'b1);     // negative second, clamped to zero
      send_doc(21'sd0, 21'sd0, 20'd0, 1'b1);             // zero total
      send_doc(21'sd5, 21'sd0, 20'd0, 1'b1);             // ratio saturates
      send_doc(21'sd0, 21'sd0, 20'hFFFFF, 1'b0);         // tiny ratios: cosine above 1.01
      send_doc(21'sd0, 21'sd0, 20'hFFFFF, 1'b1);
      send_doc(21'sd3, 21'sd7, 20'd10, 1'b0);
      send_doc(21'sd10, 21'sd1, 20'd10, 1'b0);
      send_doc(21'sd0, 21'sd10, 20'd10, 1'b1);
      send_doc(21'sd1048575, 21'sd0, 20'd1, 1'b1);
      send_doc(-21'sd1, -21'sd1, 20'd0, 1'b1);
      random_docs(130);

      write_alpha(REG_ALPHA_FIRST, 32'd0);
      write_alpha(REG_ALPHA_SECOND, 32'd0);
      send_doc(21'sd0, 21'sd0, 20'd5, 1'b1);             // zero norm
      send_doc(21'sd0, 21'sd0, 20'd0, 1'b1);             // zero over zero
      send_doc(21'sd4, 21'sd4, 20'd0, 1'b1);
      random_docs(150);

      write_alpha(REG_ALPHA_FIRST, 32'hFFFFFFFF);
      write_alpha(REG_ALPHA_SECOND, 32'hFFFFFFFF);
      send_doc(-21'sd1048576, 21'sd1048575, 20'hFFFFF, 1'b1);
      random_docs(150);

      write_alpha(REG_ALPHA_FIRST, $urandom);
      write_alpha(REG_ALPHA_SECOND, $urandom_range(0, 200000));
      random_docs(150);

      write_alpha(REG_ALPHA_FIRST, 32'd6554);
      write_alpha(REG_ALPHA_SECOND, 32'd65536);
      random_docs(150);
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

>>> filelist.f
sv/scd_pkg.sv
sv/scd_if.sv
sv/scd_front.sv
sv/scd_div.sv
sv/scd_sqrt.sv
sv/scd_back.sv
sv/smoothed_cosine_similarity_core.sv
sim/smoothed_cosine_similarity_checker.sv
sim/smoothed_cosine_similarity_core_tb.sv
